FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk_i and disabled while rst_ni is
// low. Define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/core/ssu_pkg.sv
// ----------------------------------------------------------------------------
// Sector sample unpacker package
// Sector layout constants, the sample format decode and the job record that
// passes from the front end to the back end.
// ----------------------------------------------------------------------------
package ssu_pkg;

  localparam int SectorBytes = 512;
  localparam int PosBits     = $clog2(SectorBytes);
  localparam int DataStart   = 30;
  localparam int DataEnd     = SectorBytes - 2;
  localparam int AsmBytes    = 18;
  localparam int AsmIdxBits  = $clog2(AsmBytes + 1);
  localparam int QueueDepth  = 2;

  localparam int PosLightLo  = 18;
  localparam int PosLightHi  = 19;
  localparam int PosTempLo   = 20;
  localparam int PosTempHi   = 21;
  localparam int PosFormat   = 25;
  localparam int PosCountLo  = 28;
  localparam int PosCountHi  = 29;

  localparam logic [7:0] FmtCodePacked = 8'h30;
  localparam logic [7:0] FmtCodeAxes3  = 8'h32;
  localparam logic [7:0] FmtCodeAxes6  = 8'h62;
  localparam logic [7:0] FmtCodeAxes9  = 8'h92;

  localparam logic [1:0] KindAccel = 2'd0;
  localparam logic [1:0] KindGyro  = 2'd1;
  localparam logic [1:0] KindMag   = 2'd2;

  typedef enum logic [2:0] {
    FmtNone,
    FmtPacked,
    FmtAxes3,
    FmtAxes6,
    FmtAxes9
  } fmt_e;

  typedef struct packed {
    fmt_e                       fmt;
    logic [AsmBytes-1:0][7:0]   data;
    logic [6:0]                 number;
    logic                       last;
    logic [15:0]                light_scale;
    logic [15:0]                temperature;
  } job_t;

  function automatic fmt_e fmt_decode(logic [7:0] code);
    fmt_e f;
    unique case (code)
      FmtCodePacked: f = FmtPacked;
      FmtCodeAxes3:  f = FmtAxes3;
      FmtCodeAxes6:  f = FmtAxes6;
      FmtCodeAxes9:  f = FmtAxes9;
      default:       f = FmtNone;
    endcase
    return f;
  endfunction

  function automatic logic [AsmIdxBits-1:0] bytes_per_sample(fmt_e f);
    logic [AsmIdxBits-1:0] n;
    unique case (f)
      FmtPacked: n = AsmIdxBits'(4);
      FmtAxes3:  n = AsmIdxBits'(6);
      FmtAxes6:  n = AsmIdxBits'(12);
      FmtAxes9:  n = AsmIdxBits'(18);
      default:   n = '0;
    endcase
    return n;
  endfunction

  // Highest sample index that still fits whole in the data area.
  function automatic logic [6:0] last_fit_index(fmt_e f);
    logic [6:0] n;
    unique case (f)
      FmtPacked: n = 7'((DataEnd - DataStart) / 4 - 1);
      FmtAxes3:  n = 7'((DataEnd - DataStart) / 6 - 1);
      FmtAxes6:  n = 7'((DataEnd - DataStart) / 12 - 1);
      FmtAxes9:  n = 7'((DataEnd - DataStart) / 18 - 1);
      default:   n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] final_kind(fmt_e f);
    logic [1:0] k;
    unique case (f)
      FmtAxes6: k = KindGyro;
      FmtAxes9: k = KindMag;
      default:  k = KindAccel;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/core/ssu_front.sv
// ----------------------------------------------------------------------------
// Sector sample unpacker front end
// Tracks the byte position, captures the header fields, assembles sample
// bytes and hands each complete sample within the header count to the queue as a job.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    sector_byte_i,
  input  logic          sector_start_i,
  input  logic          queue_full_i,
  output logic          job_valid_o,
  output ssu_pkg::job_t job_o
);
  import ssu_pkg::*;

  logic [PosBits-1:0]    pos_q, pos_d, pos;
  logic [15:0]           light_q, light_d;
  logic [15:0]           temp_q, temp_d;
  logic [7:0]            fmt_byte_q, fmt_byte_d;
  logic [15:0]           count_q, count_d;
  logic [AsmIdxBits-1:0] bis_q, bis_d;
  logic [6:0]            cnt_q, cnt_d;
  logic [7:0]            asm_q [AsmBytes];

  logic                  accept;
  fmt_e                  fmt;
  logic [AsmIdxBits-1:0] bps, idx, idx_next;
  logic                  in_data, done, room;

  assign accept     = in_valid_i && !queue_full_i;
  assign in_stall_o = queue_full_i;
  assign pos        = sector_start_i ? '0 : pos_q;
  assign fmt        = fmt_decode(fmt_byte_q);
  assign bps        = bytes_per_sample(fmt);
  assign in_data    = (pos >= PosBits'(DataStart)) && (pos < PosBits'(DataEnd)) &&
                      (fmt != FmtNone);
  assign idx        = (bis_q >= bps) ? '0 : bis_q;
  assign idx_next   = idx + AsmIdxBits'(1);
  assign done       = idx_next >= bps;
  assign room       = {9'd0, cnt_q} < count_q;
  assign job_valid_o = accept && in_data && done && room;

  always_comb begin
    job_o.fmt         = fmt;
    job_o.number      = cnt_q;
    job_o.light_scale = light_q;
    job_o.temperature = temp_q;
    job_o.last        = (({9'd0, cnt_q} + 16'd1) >= count_q) ||
                        (cnt_q >= last_fit_index(fmt));
    for (int g = 0; g < AsmBytes; g++) begin
      job_o.data[g] = (AsmIdxBits'(g) == idx) ? sector_byte_i : asm_q[g];
    end
  end

  always_comb begin
    pos_d      = pos_q;
    light_d    = light_q;
    temp_d     = temp_q;
    fmt_byte_d = fmt_byte_q;
    count_d    = count_q;
    bis_d      = bis_q;
    cnt_d      = cnt_q;
    if (accept) begin
      pos_d = pos + PosBits'(1);
      if (pos == '0) begin
        bis_d = '0;
        cnt_d = '0;
      end
      unique case (pos)
        PosBits'(PosLightLo): light_d[7:0]  = sector_byte_i;
        PosBits'(PosLightHi): light_d[15:8] = sector_byte_i;
        PosBits'(PosTempLo):  temp_d[7:0]   = sector_byte_i;
        PosBits'(PosTempHi):  temp_d[15:8]  = sector_byte_i;
        PosBits'(PosFormat):  fmt_byte_d    = sector_byte_i;
        PosBits'(PosCountLo): count_d[7:0]  = sector_byte_i;
        PosBits'(PosCountHi): count_d[15:8] = sector_byte_i;
        default: ;
      endcase
      if (in_data) begin
        bis_d = done ? '0 : idx_next;
        if (done && room && (cnt_q != 7'h7f)) begin
          cnt_d = cnt_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      light_q    <= '0;
      temp_q     <= '0;
      fmt_byte_q <= '0;
      count_q    <= '0;
      bis_q      <= '0;
      cnt_q      <= '0;
    end else begin
      pos_q      <= pos_d;
      light_q    <= light_d;
      temp_q     <= temp_d;
      fmt_byte_q <= fmt_byte_d;
      count_q    <= count_d;
      bis_q      <= bis_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data) begin
      asm_q[idx] <= sector_byte_i;
    end
  end

  `ASSERT_ALWAYS(a_byte_in_sample_range, bis_q < AsmIdxBits'(AsmBytes), "Sample byte index out of range.")
  `ASSERT_IMPLIES(a_job_needs_room, job_valid_o, !queue_full_i, "Job issued into a full queue.")

endmodule

FILE: rtl/core/ssu_queue.sv
// ----------------------------------------------------------------------------
// Sector sample unpacker job queue
// Short first-in first-out buffer of sample jobs between the front end and
// the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssu_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ssu_pkg::job_t job_i,
  output logic          full_o,
  output logic          head_valid_o,
  output ssu_pkg::job_t head_o,
  input  logic          pop_i
);
  import ssu_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);
  localparam int CntBits = $clog2(QueueDepth + 1);

  job_t               entry_q [QueueDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [CntBits-1:0] count_q;

  assign full_o       = count_q == CntBits'(QueueDepth);
  assign head_valid_o = count_q != '0;
  assign head_o       = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_q + PtrBits'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_q + PtrBits'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntBits'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  `ASSERT_IMPLIES(a_no_pop_when_empty, pop_i, count_q != '0, "Job queue popped while empty.")

endmodule

FILE: rtl/core/ssu_back.sv
// ----------------------------------------------------------------------------
// Sector sample unpacker back end
// Turns each queued sample job into its accelerometer, gyroscope and magnetometer
// results as its format has them, one a cycle through the output register unless out_stall_i holds it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  ssu_pkg::job_t      head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         sensor_kind_o,
  output logic signed [15:0] axis_x_o,
  output logic signed [15:0] axis_y_o,
  output logic signed [15:0] axis_z_o,
  output logic [6:0]         sample_number_o,
  output logic [2:0]         scale_code_o,
  output logic [9:0]         light_level_o,
  output logic [15:0]        temperature_level_o,
  output logic               last_in_sector_o
);
  import ssu_pkg::*;

  function automatic logic [15:0] unpack10(logic [9:0] f, logic [1:0] e);
    logic [15:0] s;
    s = {{6{f[9]}}, f};
    return s << e;
  endfunction

  function automatic logic [15:0] word16(job_t j, logic [3:0] w);
    return {j.data[{w, 1'b1}], j.data[{w, 1'b0}]};
  endfunction

  logic [1:0]  phase_q, fin;
  logic        out_valid_q, load;
  logic [15:0] x, y, z;
  logic [2:0]  scale;
  logic        last;
  logic [31:0] packed_word;

  logic [1:0]  kind_q;
  logic [15:0] x_q, y_q, z_q;
  logic [6:0]  number_q;
  logic [2:0]  scale_q;
  logic [9:0]  light_q;
  logic [15:0] temp_q;
  logic        last_q;

  assign fin         = final_kind(head_i.fmt);
  assign load        = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = load && (phase_q == fin);
  assign packed_word = {head_i.data[3], head_i.data[2], head_i.data[1], head_i.data[0]};

  always_comb begin
    x     = word16(head_i, 4'd0);
    y     = word16(head_i, 4'd1);
    z     = word16(head_i, 4'd2);
    scale = head_i.light_scale[15:13];
    last  = head_i.last && (fin == KindAccel);
    unique case (phase_q)
      KindAccel: begin
        if (head_i.fmt == FmtPacked) begin
          x = unpack10(packed_word[9:0], packed_word[31:30]);
          y = unpack10(packed_word[19:10], packed_word[31:30]);
          z = unpack10(packed_word[29:20], packed_word[31:30]);
        end else if (head_i.fmt != FmtAxes3) begin
          x = word16(head_i, 4'd3);
          y = word16(head_i, 4'd4);
          z = word16(head_i, 4'd5);
        end
      end
      KindGyro: begin
        scale = head_i.light_scale[12:10];
        last  = head_i.last && (head_i.fmt == FmtAxes6);
      end
      KindMag: begin
        x     = word16(head_i, 4'd6);
        y     = word16(head_i, 4'd7);
        z     = word16(head_i, 4'd8);
        scale = '0;
        last  = head_i.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= KindAccel;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q <= (phase_q == fin) ? KindAccel : phase_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= phase_q;
      x_q      <= x;
      y_q      <= y;
      z_q      <= z;
      number_q <= head_i.number;
      scale_q  <= scale;
      light_q  <= head_i.light_scale[9:0];
      temp_q   <= head_i.temperature;
      last_q   <= last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign sensor_kind_o       = kind_q;
  assign axis_x_o            = $signed(x_q);
  assign axis_y_o            = $signed(y_q);
  assign axis_z_o            = $signed(z_q);
  assign sample_number_o     = number_q;
  assign scale_code_o        = scale_q;
  assign light_level_o       = light_q;
  assign temperature_level_o = temp_q;
  assign last_in_sector_o    = last_q;

  `ASSERT_IMPLIES(a_phase_needs_job, phase_q != KindAccel, head_valid_i, "Result phase open without a job.")
  `ASSERT_IMPLIES(a_phase_in_range, head_valid_i, phase_q <= fin, "Result phase beyond the format.")

endmodule

FILE: rtl/core/sensor_sector_sample_unpacker.sv
// ----------------------------------------------------------------------------
// Sensor sector sample unpacker
// Parses 512-byte logger data sectors byte by byte and emits raw sensor
// triples with their scale codes and sector header values.
//
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i/in_stall_o   sector_byte_i, sector_start_i
//   out      source     out_valid_o/out_stall_i sensor_kind_o .. last_in_sector_o
//
// One sector byte is accepted every cycle while in_stall_o is low. A complete
// sample gives one to three results, issued one a cycle from the output register
// unless out_stall_i holds it, the first after the sample's final byte passes the
// job queue. A two-entry job queue separates byte parsing from result generation;
// in_stall_o rises only when both entries are held, i.e. when out_stall_i has held
// results back. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module sensor_sector_sample_unpacker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         sector_byte_i,
  input  logic               sector_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         sensor_kind_o,
  output logic signed [15:0] axis_x_o,
  output logic signed [15:0] axis_y_o,
  output logic signed [15:0] axis_z_o,
  output logic [6:0]         sample_number_o,
  output logic [2:0]         scale_code_o,
  output logic [9:0]         light_level_o,
  output logic [15:0]        temperature_level_o,
  output logic               last_in_sector_o
);
  import ssu_pkg::*;

  logic job_valid, queue_full, head_valid, pop;
  job_t job, head;

  ssu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sector_byte_i  (sector_byte_i),
    .sector_start_i (sector_start_i),
    .queue_full_i   (queue_full),
    .job_valid_o    (job_valid),
    .job_o          (job)
  );

  ssu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (job_valid),
    .job_i        (job),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  ssu_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_valid_i        (head_valid),
    .head_i              (head),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .sensor_kind_o       (sensor_kind_o),
    .axis_x_o            (axis_x_o),
    .axis_y_o            (axis_y_o),
    .axis_z_o            (axis_z_o),
    .sample_number_o     (sample_number_o),
    .scale_code_o        (scale_code_o),
    .light_level_o       (light_level_o),
    .temperature_level_o (temperature_level_o),
    .last_in_sector_o    (last_in_sector_o)
  );

endmodule

FILE: test/sensor_sector_sample_unpacker_test.sv
// ----------------------------------------------------------------------------
// Sensor sector sample unpacker testbench
// Streams logger data sectors into the unpacker, one byte per transaction,
// with random idle cycles on both channels. Every sensor triple is checked
// field by field against a typed sector's listed result or else a predictor of the
// header capture and the sample decode. A short table of sectors comes first.
// Random sectors follow: some are full length, some wrap into the next sector
// without a start mark, and most are short sectors that a start mark cuts off.
// ----------------------------------------------------------------------------
module sensor_sector_sample_unpacker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssu_pkg::*;

  localparam int HeaderBytes   = 30;
  localparam int DataBytes     = 480;
  localparam int FillBytes     = 482;
  localparam int AssemblyBytes = 18;
  localparam int LightLoAt     = 18;
  localparam int LightHiAt     = 19;
  localparam int TempLoAt      = 20;
  localparam int TempHiAt      = 21;
  localparam int FormatAt      = 25;
  localparam int CountLoAt     = 28;
  localparam int CountHiAt     = 29;

  localparam logic [7:0] NoFormat  = 8'h00;
  localparam logic [7:0] BadFormat = 8'h93;

  localparam int RandomItems  = 310;
  localparam int LongHold     = 300;
  localparam int DrainLimit   = 5000;
  localparam int SettleCycles = 10;
  localparam int CycleLimit   = 500_000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [6:0]  number;
    logic [2:0]  scale;
    logic [9:0]  light;
    logic [15:0] temp;
    logic        last;
  } triple_t;

  typedef struct packed {
    logic [15:0] light;
    logic [15:0] temp;
    logic [7:0]  fmt;
    logic [15:0] count;
    logic [31:0] fill;
    logic [9:0]  data_len;
    logic        scramble;
    logic        typed;
    logic        has_result;
    triple_t     result;
  } sector_case_t;

  localparam sector_case_t DirectedSectors [10] = '{
    '{16'h1234, 16'h5678, NoFormat, 16'd5, 32'hFFFF_FFFF, 10'd40, 1'b0, 1'b1, 1'b0, '0},
    '{16'hFFFF, 16'hFFFF, FmtCodePacked, 16'd1, 32'hFFFF_FFFF, 10'd4, 1'b0, 1'b1, 1'b1,
      '{KindAccel, 16'hFFF8, 16'hFFF8, 16'hFFF8, 7'd0, 3'd7, 10'h3FF, 16'hFFFF, 1'b1}},
    '{16'h0000, 16'h0000, FmtCodePacked, 16'd1, 32'h1FF7_FDFF, 10'd4, 1'b0, 1'b1, 1'b1,
      '{KindAccel, 16'h01FF, 16'h01FF, 16'h01FF, 7'd0, 3'd0, 10'h000, 16'h0000, 1'b1}},
    '{16'h03FF, 16'h8000, FmtCodePacked, 16'd1, 32'hE008_0200, 10'd4, 1'b0, 1'b1, 1'b1,
      '{KindAccel, 16'hF000, 16'hF000, 16'hF000, 7'd0, 3'd0, 10'h3FF, 16'h8000, 1'b1}},
    '{16'hFFFF, 16'h0000, FmtCodeAxes3, 16'd0, 32'hFFFF_FFFF, 10'd12, 1'b0, 1'b1, 1'b0, '0},
    '{16'hA5A5, 16'h0001, FmtCodeAxes3, 16'd3, 32'h8000_7FFF, 10'd20, 1'b0, 1'b0, 1'b0, '0},
    '{16'h7C00, 16'hFFFF, FmtCodeAxes6, 16'd2, 32'h1234_5678, 10'd24, 1'b0, 1'b0, 1'b0, '0},
    '{16'hFFFF, 16'h7FFF, FmtCodeAxes9, 16'hFFFF, 32'h8001_7FFE, 10'd40, 1'b0, 1'b0, 1'b0,
      '0},
    '{16'h5A5A, 16'h0100, BadFormat, 16'd10, 32'h0000_0000, 10'd20, 1'b0, 1'b1, 1'b0, '0},
    '{16'h1C00, 16'h00FF, FmtCodeAxes6, 16'd1, 32'h0000_0000, 10'd12, 1'b1, 1'b0, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [7:0]         sector_byte_i  = 8'h00;
  logic               sector_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [1:0]         sensor_kind_o;
  logic signed [15:0] axis_x_o;
  logic signed [15:0] axis_y_o;
  logic signed [15:0] axis_z_o;
  logic [6:0]         sample_number_o;
  logic [2:0]         scale_code_o;
  logic [9:0]         light_level_o;
  logic [15:0]        temperature_level_o;
  logic               last_in_sector_o;

  logic [8:0]  at_q      = '0;
  logic [15:0] light_q   = '0;
  logic [15:0] temp_q    = '0;
  logic [7:0]  format_q  = '0;
  logic [15:0] count_q   = '0;
  logic [7:0]  sample_bytes_q [AssemblyBytes];
  int          filled_q  = 0;
  logic [6:0]  number_q  = '0;

  triple_t triples_new [$];
  triple_t triples_due [$];
  int      faults      = 0;
  int      fed         = 0;
  int      holds_asked = 0;
  int      holds_done  = 0;
  bit      feed_calm   = 1'b0;
  bit      sink_calm   = 1'b0;

  sensor_sector_sample_unpacker dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .sector_byte_i      (sector_byte_i),
    .sector_start_i     (sector_start_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .sensor_kind_o      (sensor_kind_o),
    .axis_x_o           (axis_x_o),
    .axis_y_o           (axis_y_o),
    .axis_z_o           (axis_z_o),
    .sample_number_o    (sample_number_o),
    .scale_code_o       (scale_code_o),
    .light_level_o      (light_level_o),
    .temperature_level_o(temperature_level_o),
    .last_in_sector_o   (last_in_sector_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int sample_size(logic [7:0] fmt);
    if (fmt == FmtCodePacked) return 4;
    if (fmt == FmtCodeAxes3) return 6;
    if (fmt == FmtCodeAxes6) return 12;
    if (fmt == FmtCodeAxes9) return 18;
    return 0;
  endfunction

  function automatic logic [15:0] word_at(int w);
    return {sample_bytes_q[2 * w + 1], sample_bytes_q[2 * w]};
  endfunction

  function automatic logic [15:0] widen10(logic [9:0] f, logic [1:0] e);
    logic signed [15:0] v;
    v = {{6{f[9]}}, f};
    return v <<< e;
  endfunction

  function automatic void note(input logic [1:0] kind, input logic [15:0] x, y, z,
                               input logic [2:0] scale, input logic last);
    triple_t t;
    t = '{kind, x, y, z, number_q, scale, light_q[9:0], temp_q, last};
    triples_new.push_back(t);
  endfunction

  function automatic void unpack_byte(logic [7:0] b, logic mark);
    int          size;
    int          slot;
    logic [31:0] word;
    logic        last;
    if (mark) at_q = '0;
    if (at_q == '0) begin
      filled_q = 0;
      number_q = '0;
    end
    case (int'(at_q))
      LightLoAt: light_q[7:0]  = b;
      LightHiAt: light_q[15:8] = b;
      TempLoAt:  temp_q[7:0]   = b;
      TempHiAt:  temp_q[15:8]  = b;
      FormatAt:  format_q      = b;
      CountLoAt: count_q[7:0]  = b;
      CountHiAt: count_q[15:8] = b;
      default: ;
    endcase
    size = sample_size(format_q);
    if (int'(at_q) >= HeaderBytes && int'(at_q) < HeaderBytes + DataBytes && size != 0) begin
      slot = (filled_q >= size) ? 0 : filled_q;
      sample_bytes_q[slot] = b;
      slot++;
      if (slot >= size) begin
        slot = 0;
        if (16'(number_q) < count_q) begin
          last = (int'(number_q) + 1 >= int'(count_q)) ||
                 ((int'(number_q) + 2) * size > DataBytes);
          if (size == 4) begin
            word = {sample_bytes_q[3], sample_bytes_q[2], sample_bytes_q[1], sample_bytes_q[0]};
            note(KindAccel, widen10(word[9:0], word[31:30]), widen10(word[19:10], word[31:30]),
                 widen10(word[29:20], word[31:30]), light_q[15:13], last);
          end else if (format_q == FmtCodeAxes3) begin
            note(KindAccel, word_at(0), word_at(1), word_at(2), light_q[15:13], last);
          end else begin
            note(KindAccel, word_at(3), word_at(4), word_at(5), light_q[15:13], 1'b0);
            note(KindGyro, word_at(0), word_at(1), word_at(2), light_q[12:10],
                 format_q == FmtCodeAxes6 && last);
            if (format_q == FmtCodeAxes9) begin
              note(KindMag, word_at(6), word_at(7), word_at(8), 3'd0, last);
            end
          end
          if (number_q < 7'd127) number_q++;
        end
      end
      filled_q = slot;
    end
    at_q = at_q + 9'd1;
  endfunction

  function automatic int idle_draw(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      faults++;
    end
  endfunction

  task automatic feed_byte(input logic [7:0] b, input logic mark, input bit keep);
    int gap;
    gap = idle_draw(feed_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sector_byte_i  <= b;
    sector_start_i <= mark;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fed++;
    unpack_byte(b, mark);
    if (keep) begin
      foreach (triples_new[i]) triples_due.push_back(triples_new[i]);
    end
    triples_new.delete();
  endtask

  task automatic send_sector(input sector_case_t c, input bit mark);
    logic [7:0] b;
    for (int p = 0; p < HeaderBytes + int'(c.data_len); p++) begin
      case (p)
        LightLoAt: b = c.light[7:0];
        LightHiAt: b = c.light[15:8];
        TempLoAt:  b = c.temp[7:0];
        TempHiAt:  b = c.temp[15:8];
        FormatAt:  b = c.fmt;
        CountLoAt: b = c.count[7:0];
        CountHiAt: b = c.count[15:8];
        default: begin
          if (p < HeaderBytes || c.scramble) b = 8'($urandom);
          else b = c.fill[8 * ((p - HeaderBytes) % 4) +: 8];
        end
      endcase
      feed_byte(b, mark && p == 0, !c.typed);
    end
    if (c.typed && c.has_result) triples_due.push_back(c.result);
  endtask

  always @(posedge clk_i) begin : result_check
    triple_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (triples_due.size() == 0) begin
        $error("sensor triple arrived with nothing expected");
        faults++;
      end else begin
        want = triples_due.pop_front();
        check_field("sensor_kind", 16'(want.kind), 16'(sensor_kind_o));
        check_field("axis_x", want.x, axis_x_o);
        check_field("axis_y", want.y, axis_y_o);
        check_field("axis_z", want.z, axis_z_o);
        check_field("sample_number", 16'(want.number), 16'(sample_number_o));
        check_field("scale_code", 16'(want.scale), 16'(scale_code_o));
        check_field("light_level", 16'(want.light), 16'(light_level_o));
        check_field("temperature_level", want.temp, temperature_level_o);
        check_field("last_in_sector", 16'(want.last), 16'(last_in_sector_o));
      end
    end
  end

  // The long hold lets the job queue fill so that the input side stalls.
  initial begin : result_sink
    int pause;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (holds_done != holds_asked) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        holds_done++;
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        pause = idle_draw(sink_calm);
        if (pause > 0) begin
          out_stall_i <= 1'b1;
          repeat (pause) @(posedge clk_i);
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned ticks;
    ticks = 0;
    while (ticks < CycleLimit) begin
      @(posedge clk_i);
      ticks++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    sector_case_t c;
    int           size;
    int           span;
    int           short_fed;
    int           settle;
    bit           wrap_next;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(DirectedSectors); i++) send_sector(DirectedSectors[i], 1'b1);

    wrap_next = 1'b0;
    short_fed = 0;
    for (int n = 0; n < 4 || short_fed < RandomItems; n++) begin
      feed_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      if ((n == 4 || (n > 4 && $urandom_range(0, 5) == 0)) && triples_due.size() > 0) begin
        in_valid_i <= 1'b0;
        while (triples_due.size() > 0) @(posedge clk_i);
      end
      c.light      = 16'($urandom);
      c.temp       = 16'($urandom);
      c.fill       = '0;
      c.scramble   = 1'b1;
      c.typed      = 1'b0;
      c.has_result = 1'b0;
      c.result     = '0;
      case ($urandom_range(0, 8))
        0, 1:    c.fmt = FmtCodePacked;
        2, 3:    c.fmt = FmtCodeAxes3;
        4, 5:    c.fmt = FmtCodeAxes6;
        6, 7:    c.fmt = FmtCodeAxes9;
        default: c.fmt = 8'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       c.count = 16'($urandom);
        1, 2:    c.count = 16'($urandom_range(0, 130));
        default: c.count = 16'($urandom_range(0, 4));
      endcase
      size = sample_size(c.fmt);
      if ($urandom_range(0, 11) == 0) begin
        c.data_len = 10'(FillBytes);
      end else if (size > 0 && $urandom_range(0, 2) != 0) begin
        span = int'(c.count) * size + $urandom_range(0, 3);
        c.data_len = 10'((span > FillBytes) ? FillBytes : span);
      end else begin
        c.data_len = 10'($urandom_range(0, 60));
      end
      case (n)
        0: begin
          c.fmt      = FmtCodeAxes3;
          c.count    = 16'($urandom_range(75, 200));
          c.data_len = 10'(FillBytes);
          feed_calm  = 1'b1;
          holds_asked++;
        end
        1: begin
          c.fmt      = FmtCodeAxes9;
          c.count    = 16'hFFFF;
          c.data_len = 10'(FillBytes);
        end
        2: begin
          c.fmt      = FmtCodePacked;
          c.count    = 16'($urandom_range(100, 300));
          c.data_len = 10'(FillBytes);
        end
        default: ;
      endcase
      send_sector(c, !wrap_next);
      if (n >= 3) short_fed += HeaderBytes + int'(c.data_len);
      wrap_next = (int'(c.data_len) == FillBytes) && (n == 2 || $urandom_range(0, 1) == 0);
    end
    in_valid_i <= 1'b0;

    settle = 0;
    while (triples_due.size() > 0 && settle < DrainLimit) begin
      @(posedge clk_i);
      settle++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (triples_due.size() > 0) begin
      $error("%0d expected sensor triples never arrived", triples_due.size());
      faults++;
    end
    if (faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ssu_pkg.sv
rtl/core/ssu_front.sv
rtl/core/ssu_queue.sv
rtl/core/ssu_back.sv
rtl/core/sensor_sector_sample_unpacker.sv
test/sensor_sector_sample_unpacker_test.sv
